// ===== rtl/delta_sample_block_decoder_defines.svh =====
// Assertion macros shared by the decoder's modules.
// Each module that uses them must have clk and rst_n in scope.
`ifndef DELTA_SAMPLE_BLOCK_DECODER_DEFINES_SVH
`define DELTA_SAMPLE_BLOCK_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising edge while out of reset.
`define DSBD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dsbd assertion failed");

// Checked on every rising edge, reset included.
`define DSBD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("dsbd assertion failed");

`else

`define DSBD_ASSERT(lbl, prop)
`define DSBD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/dsbd_pkg.sv =====
package dsbd_pkg;

    // Parser phases.
    localparam logic [1:0] PH_HDR0  = 2'd0;
    localparam logic [1:0] PH_HDR   = 2'd1;
    localparam logic [1:0] PH_FIRST = 2'd2;
    localparam logic [1:0] PH_DIFF  = 2'd3;

    // Header lengths in bytes.
    localparam logic [2:0] HDR_LEN_SHORT = 3'd4;
    localparam logic [2:0] HDR_LEN_LONG  = 3'd5;

    // Difference size codes.
    localparam logic [2:0] SIZE_NIBBLE = 3'd0;
    localparam logic [2:0] SIZE_BYTE1  = 3'd1;
    localparam logic [2:0] SIZE_BYTE2  = 3'd2;
    localparam logic [2:0] SIZE_BYTE3  = 3'd3;
    localparam logic [2:0] SIZE_BYTE4  = 3'd4;

    // Number of byte-group entries held between parser and output.
    localparam int QUEUE_DEPTH = 2;

    // Up to two results caused by one input byte. The second result shares
    // the header fields and follows the first at the next index.
    typedef struct packed {
        logic [15:0]        channel;
        logic [19:0]        rate;
        logic [19:0]        index;
        logic signed [31:0] val0;
        logic signed [31:0] val1;
        logic               last0;
        logic               last1;
        logic               bad;
        logic               two;
    } pair_t;

endpackage

// ===== rtl/dsbd_parse.sv =====
`include "delta_sample_block_decoder_defines.svh"

module dsbd_parse
    import dsbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        group_start,
    output logic        push,
    output pair_t       pair
);

    logic [1:0]         phase_reg, phase_next;
    logic [2:0]         count_reg, count_next;
    logic [15:0]        channel_reg, channel_next;
    logic [19:0]        rate_reg, rate_next;
    logic [2:0]         size_reg, size_next;
    logic               long_reg, long_next;
    logic [19:0]        index_reg, index_next;
    logic signed [31:0] value_reg, value_next;
    logic [23:0]        asm_reg, asm_next;

    logic [2:0]         count_inc;
    logic [19:0]        rate_shift;
    logic               hdr_done;
    logic [19:0]        index_inc1;
    logic [19:0]        index_inc2;
    logic               last_inc1;
    logic               last_inc2;
    logic [3:0]         nib_hi;
    logic [3:0]         nib_lo;
    logic [4:0]         nib_sum;
    logic signed [31:0] sum_hi;
    logic signed [31:0] sum_pair;
    logic signed [31:0] diff;
    logic signed [31:0] sum_diff;
    logic [31:0]        first_val;

    // Shared arithmetic for the header and the sample path.
    always_comb
    begin
        count_inc  = count_reg + 3'd1;
        rate_shift = {rate_reg[11:0], data_byte};
        hdr_done   = long_reg ? (count_inc == HDR_LEN_LONG) : (count_inc == HDR_LEN_SHORT);
        index_inc1 = index_reg + 20'd1;
        index_inc2 = index_reg + 20'd2;
        last_inc1  = (index_inc1 == rate_reg);
        last_inc2  = (index_inc2 == rate_reg);
        nib_hi     = data_byte[7:4];
        nib_lo     = data_byte[3:0];
        nib_sum    = {nib_hi[3], nib_hi} + {nib_lo[3], nib_lo};
        sum_hi     = value_reg + {{28{nib_hi[3]}}, nib_hi};
        sum_pair   = value_reg + {{27{nib_sum[4]}}, nib_sum};
        first_val  = {asm_reg, data_byte};
        unique case (size_reg)
            SIZE_BYTE1: diff = {{24{data_byte[7]}}, data_byte};
            SIZE_BYTE2: diff = {{16{asm_reg[7]}}, asm_reg[7:0], data_byte};
            SIZE_BYTE3: diff = {{8{asm_reg[15]}}, asm_reg[15:0], data_byte};
            default:    diff = {asm_reg, data_byte};
        endcase
        sum_diff   = value_reg + diff;
    end

    // Next state and the results of the accepted word.
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        channel_next = channel_reg;
        rate_next    = rate_reg;
        size_next    = size_reg;
        long_next    = long_reg;
        index_next   = index_reg;
        value_next   = value_reg;
        asm_next     = asm_reg;

        push       = 1'b0;
        pair.channel = channel_reg;
        pair.rate  = rate_reg;
        pair.index = index_reg;
        pair.val0  = sum_diff;
        pair.val1  = sum_pair;
        pair.last0 = last_inc1;
        pair.last1 = last_inc2;
        pair.bad   = 1'b0;
        pair.two   = 1'b0;

        if (accept)
        begin
            if (group_start || phase_reg == PH_HDR0)
            begin
                channel_next = {data_byte, 8'h00};
                phase_next   = PH_HDR;
                count_next   = 3'd1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HDR:
                    begin
                        if (count_reg == 3'd1)
                        begin
                            channel_next = {channel_reg[15:8], data_byte};
                            count_next   = 3'd2;
                        end
                        else if (count_reg == 3'd2)
                        begin
                            long_next  = data_byte[7];
                            size_next  = data_byte[6:4];
                            rate_next  = {16'h0000, data_byte[3:0]};
                            count_next = 3'd3;
                        end
                        else
                        begin
                            rate_next  = rate_shift;
                            count_next = count_inc;
                            if (hdr_done)
                            begin
                                index_next = 20'd0;
                                count_next = 3'd0;
                                asm_next   = 24'd0;
                                if (size_reg > SIZE_BYTE4 || rate_shift == 20'd0)
                                begin
                                    // Malformed header: one error word, then a new header.
                                    push       = 1'b1;
                                    pair.rate  = rate_shift;
                                    pair.index = 20'd0;
                                    pair.val0  = 32'sd0;
                                    pair.last0 = 1'b1;
                                    pair.bad   = 1'b1;
                                    phase_next = PH_HDR0;
                                end
                                else
                                begin
                                    phase_next = PH_FIRST;
                                end
                            end
                        end
                    end

                    PH_FIRST:
                    begin
                        if (count_reg < 3'd3)
                        begin
                            asm_next   = {asm_reg[15:0], data_byte};
                            count_next = count_inc;
                        end
                        else
                        begin
                            // The first sample stands as it is.
                            push       = 1'b1;
                            pair.val0  = first_val;
                            value_next = first_val;
                            index_next = index_inc1;
                            count_next = 3'd0;
                            asm_next   = 24'd0;
                            phase_next = last_inc1 ? PH_HDR0 : PH_DIFF;
                        end
                    end

                    default:
                    begin
                        if (size_reg == SIZE_NIBBLE)
                        begin
                            // Nibble differences, high nibble first; the low one only if the block has room.
                            push      = 1'b1;
                            pair.val0 = sum_hi;
                            if (last_inc1)
                            begin
                                value_next = sum_hi;
                                index_next = index_inc1;
                                count_next = 3'd0;
                                phase_next = PH_HDR0;
                            end
                            else
                            begin
                                pair.two   = 1'b1;
                                value_next = sum_pair;
                                index_next = index_inc2;
                                if (last_inc2)
                                begin
                                    count_next = 3'd0;
                                    phase_next = PH_HDR0;
                                end
                            end
                        end
                        else if ({1'b0, count_inc} < {1'b0, size_reg})
                        begin
                            asm_next   = {asm_reg[15:0], data_byte};
                            count_next = count_inc;
                        end
                        else
                        begin
                            // Whole difference assembled.
                            push       = 1'b1;
                            value_next = sum_diff;
                            index_next = index_inc1;
                            count_next = 3'd0;
                            asm_next   = 24'd0;
                            if (last_inc1)
                            begin
                                phase_next = PH_HDR0;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // All state, control and data alike, is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            count_reg   <= 3'd0;
            channel_reg <= 16'd0;
            rate_reg    <= 20'd0;
            size_reg    <= 3'd0;
            long_reg    <= 1'b0;
            index_reg   <= 20'd0;
            value_reg   <= 32'sd0;
            asm_reg     <= 24'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            channel_reg <= channel_next;
            rate_reg    <= rate_next;
            size_reg    <= size_next;
            long_reg    <= long_next;
            index_reg   <= index_next;
            value_reg   <= value_next;
            asm_reg     <= asm_next;
        end
    end

    // A difference phase is only entered with a valid size code.
    `DSBD_ASSERT(a_diff_size_ok, (phase_reg == PH_DIFF) |-> (size_reg <= SIZE_BYTE4))
    // Inside a block the first sample has always been delivered.
    `DSBD_ASSERT(a_diff_index_nonzero, (phase_reg == PH_DIFF) |-> (index_reg != 20'd0))

endmodule

// ===== rtl/dsbd_queue.sv =====
`include "delta_sample_block_decoder_defines.svh"

module dsbd_queue
    import dsbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pair_t              pair,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        channel_id,
    output logic [19:0]        sample_rate,
    output logic [19:0]        sample_index,
    output logic signed [31:0] sample_value,
    output logic               last_sample,
    output logic               bad_header
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pair_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               half_reg, half_next;
    pair_t              head;
    logic               pop_word;
    logic               entry_done;

    // Head entry and the word it currently presents.
    always_comb
    begin
        head         = entry_reg[rd_ptr_reg];
        out_valid    = (count_reg != '0);
        full         = (count_reg == CNT_W'(QUEUE_DEPTH));
        channel_id   = head.channel;
        sample_rate  = head.rate;
        sample_index = half_reg ? (head.index + 20'd1) : head.index;
        sample_value = half_reg ? head.val1 : head.val0;
        last_sample  = half_reg ? head.last1 : head.last0;
        bad_header   = half_reg ? 1'b0 : head.bad;
    end

    // Pointer, fill and half-select bookkeeping.
    always_comb
    begin
        pop_word    = out_valid && !out_stall;
        entry_done  = pop_word && (!head.two || half_reg);
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = entry_done ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(entry_done);
        if (entry_done)
        begin
            half_next = 1'b0;
        end
        else if (pop_word)
        begin
            half_next = 1'b1;
        end
        else
        begin
            half_next = half_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            half_reg   <= half_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= pair;
        end
    end

    // The fill level never exceeds the depth.
    `DSBD_ASSERT(a_count_max, count_reg <= CNT_W'(QUEUE_DEPTH))
    // Nothing is written into a full queue.
    `DSBD_ASSERT(a_no_push_full, push |-> !full)
    // The second half is only presented for an entry that holds two words.
    `DSBD_ASSERT(a_half_pair, half_reg |-> (out_valid && head.two))
    // The output word runs out only after a word has been taken.
    `DSBD_ASSERT(a_fall_after_pop, $fell(out_valid) |-> $past(pop_word))

endmodule

// ===== rtl/delta_sample_block_decoder.sv =====
// Channel  Direction  Handshake            Word
// input    in         in_valid / in_stall   data_byte, group_start
// output   out        out_valid / out_stall channel_id, sample_rate, sample_index,
//                                           sample_value, last_sample, bad_header
//
// One input word is taken per cycle while in_stall is low; its samples are
// registered into a two-entry queue of result groups and presented from it.
// A nibble-coded byte yields two output words, or one when it ends the block,
// so such streams run at the output rate: one word per cycle when not stalled.
// in_stall is high only while both queue entries hold undelivered words.
// Reset (rst_n low) returns the parser to header byte 0 and empties the queue.
module delta_sample_block_decoder
    import dsbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               group_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        channel_id,
    output logic [19:0]        sample_rate,
    output logic [19:0]        sample_index,
    output logic signed [31:0] sample_value,
    output logic               last_sample,
    output logic               bad_header
);

    logic  accept;
    logic  push;
    logic  full;
    pair_t pair;

    // A word is taken whenever there is room for its results.
    assign in_stall = full;
    assign accept   = in_valid && !full;

    dsbd_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .group_start (group_start),
        .push        (push),
        .pair        (pair)
    );

    dsbd_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .pair         (pair),
        .full         (full),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .channel_id   (channel_id),
        .sample_rate  (sample_rate),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .last_sample  (last_sample),
        .bad_header   (bad_header)
    );

endmodule
